@@ rtl/core/rit_pkg.sv @@
// ----------------------------------------------------------------------------
// rit_pkg
// Types and codes shared by the identifier translator and its table cells.
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam logic [3:0] MODE_O2N       = 4'd0;
    localparam logic [3:0] MODE_O2N_SPEC  = 4'd1;
    localparam logic [3:0] MODE_N2O       = 4'd2;
    localparam logic [3:0] MODE_ADD_SPEC  = 4'd3;
    localparam logic [3:0] MODE_ADD_ATOM  = 4'd4;
    localparam logic [3:0] MODE_ATOM_FWD  = 4'd5;
    localparam logic [3:0] MODE_ATOM_REV  = 4'd6;
    localparam logic [3:0] MODE_SPEC_LOOK = 4'd7;
    localparam logic [3:0] MODE_CHK_OLD   = 4'd8;
    localparam logic [3:0] MODE_CHK_NEW   = 4'd9;

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_STORED = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [2:0] REG_OLD_BASE = 3'd0;
    localparam logic [2:0] REG_OLD_MASK = 3'd1;
    localparam logic [2:0] REG_NEW_BASE = 3'd2;
    localparam logic [2:0] REG_NEW_MASK = 3'd3;
    localparam logic [2:0] REG_OLD_ROOT = 3'd4;
    localparam logic [2:0] REG_NEW_ROOT = 3'd5;

    localparam logic [31:0] ATOM_PASS_LIMIT = 32'd68;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] id;
        logic [31:0] partner_id;
    } req_t;

    typedef struct packed {
        logic [31:0] result_id;
        logic [1:0]  status;
    } rsp_t;

    // token passed cell to cell along a table chain
    typedef struct packed {
        logic        active;
        logic        wr;       // insert operation
        logic        commit;   // write pass (second sweep)
        logic [31:0] key;
        logic [31:0] value;
        logic        hit;
        logic [31:0] hit_value;
        logic        free_seen;
        logic        claimed;  // commit already placed
    } tok_t;

endpackage

@@ rtl/core/rit_cell.sv @@
// ----------------------------------------------------------------------------
// rit_cell
// One table entry: compares the passing token with its key and updates it.
// ----------------------------------------------------------------------------
module rit_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  rit_pkg::tok_t  tok_in,
    output rit_pkg::tok_t  tok_out
);

    logic        valid_reg;
    logic [31:0] key_reg;
    logic [31:0] value_reg;
    logic        match;
    logic        do_write;
    rit_pkg::tok_t tok_next;
    rit_pkg::tok_t tok_reg;

    assign match = valid_reg && (key_reg == tok_in.key);

    // on the commit pass the earlier search decided: hit -> write the match,
    // else write the first free entry
    assign do_write = tok_in.active && tok_in.commit && !tok_in.claimed &&
                      (tok_in.hit ? match : !valid_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.commit)
        begin
            if (match && !tok_in.hit)
            begin
                tok_next.hit       = 1'b1;
                tok_next.hit_value = value_reg;
            end
            if (!valid_reg)
                tok_next.free_seen = 1'b1;
        end
        if (do_write)
            tok_next.claimed = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (do_write)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            key_reg   <= tok_in.key;
            value_reg <= tok_in.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/core/rit_chain.sv @@
// ----------------------------------------------------------------------------
// rit_chain
// A row of table cells; a token enters at cell zero, passes each cell's
// register in turn and exits at the last one carrying the search outcome.
// ----------------------------------------------------------------------------
module rit_chain #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rit_pkg::tok_t  tok_in,
    output rit_pkg::tok_t  tok_out
);

    rit_pkg::tok_t link [DEPTH+1];

    assign link[0] = tok_in;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        rit_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[g]),
            .tok_out (link[g+1])
        );
    end

    assign tok_out = link[DEPTH];

endmodule

@@ rtl/core/resource_id_translator.sv @@
// ----------------------------------------------------------------------------
// resource_id_translator
// Translates identifiers between an old and a new numbering space.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel (valid/ready) as a mode, an id and a
//   partner id; each transaction returns exactly one transaction on the rsp
//   channel with a result id and a status.
//   Window and root translations and range checks need no table pass.
//   Table operations send a token down a chain of cells, one cell per cycle:
//   a lookup makes one pass down its table (SPECIAL_ENTRIES or
//   ATOM_ENTRIES cells); an insert takes a search pass and, unless the table
//   is full, a commit pass, and the atom insert runs both atom chains side by side.
//   One transaction is in flight at a time; the cell chain latency sets the
//   rate.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   and must only change while the block is idle.
//   Reset clears control, configuration and token registers and valid bits;
//   keys, values, request and response hold no reset. On a stall the result
//   holds in the output register; no new request is taken until it is taken.
// ----------------------------------------------------------------------------
module resource_id_translator #(
    parameter int SPECIAL_ENTRIES = 16,
    parameter int ATOM_ENTRIES    = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rit_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rit_pkg::rsp_t   rsp,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_COMMIT = 3'd2;
    localparam logic [2:0] S_OUT    = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [31:0] old_base_reg, old_mask_reg, new_base_reg, new_mask_reg;
    logic [31:0] old_root_reg, new_root_reg;
    rit_pkg::req_t req_reg;
    rit_pkg::rsp_t rsp_reg, rsp_next;

    rit_pkg::tok_t sp_in, sp_out, af_in, af_out, ar_in, ar_out;

    logic accept;
    logic [31:0] fb, fr, tb, tr;
    logic in_win_old, in_win_new, in_win_from;
    logic use_spec, use_atom, is_ins, low_atom;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;

    // hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_base_reg <= '0;
            old_mask_reg <= '0;
            new_base_reg <= '0;
            new_mask_reg <= '0;
            old_root_reg <= '0;
            new_root_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rit_pkg::REG_OLD_BASE: old_base_reg <= cfg_data;
                rit_pkg::REG_OLD_MASK: old_mask_reg <= cfg_data;
                rit_pkg::REG_NEW_BASE: new_base_reg <= cfg_data;
                rit_pkg::REG_NEW_MASK: new_mask_reg <= cfg_data;
                rit_pkg::REG_OLD_ROOT: old_root_reg <= cfg_data;
                rit_pkg::REG_NEW_ROOT: new_root_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode the held request
    assign in_win_old = (req_reg.id >= old_base_reg) &&
                        (req_reg.id <= (old_base_reg | old_mask_reg));
    assign in_win_new = (req_reg.id >= new_base_reg) &&
                        (req_reg.id <= (new_base_reg | new_mask_reg));
    assign low_atom   = (req_reg.id <= rit_pkg::ATOM_PASS_LIMIT);

    always_comb
    begin
        if (req_reg.mode == rit_pkg::MODE_N2O)
        begin
            fb = new_base_reg; fr = new_root_reg;
            tb = old_base_reg; tr = old_root_reg; in_win_from = in_win_new;
        end
        else
        begin
            fb = old_base_reg; fr = old_root_reg;
            tb = new_base_reg; tr = new_root_reg; in_win_from = in_win_old;
        end
    end

    // which table work the request needs
    always_comb
    begin
        use_spec = 1'b0;
        use_atom = 1'b0;
        is_ins   = 1'b0;
        unique case (req_reg.mode) inside
            rit_pkg::MODE_O2N_SPEC:
                use_spec = (req_reg.id != '0) && (req_reg.id != fr) && !in_win_from;
            rit_pkg::MODE_SPEC_LOOK: use_spec = 1'b1;
            rit_pkg::MODE_ADD_SPEC:
            begin
                use_spec = 1'b1;
                is_ins   = 1'b1;
            end
            rit_pkg::MODE_ATOM_FWD, rit_pkg::MODE_ATOM_REV: use_atom = !low_atom;
            rit_pkg::MODE_ADD_ATOM:
            begin
                use_atom = !low_atom;
                is_ins   = !low_atom;
            end
            default: ;
        endcase
    end

    // launch tokens in the first cycle of SEARCH or COMMIT, then wait for the exit
    logic launch_reg;
    logic spec_done, atom_done, pass_done;
    assign spec_done = sp_out.active;
    assign atom_done = af_out.active;
    assign pass_done = use_spec ? spec_done : atom_done;

    always_comb
    begin
        sp_in = '0;
        af_in = '0;
        ar_in = '0;
        if (launch_reg && (state_reg == S_SEARCH || state_reg == S_COMMIT))
        begin
            sp_in.active = use_spec;
            sp_in.wr     = is_ins;
            sp_in.commit = (state_reg == S_COMMIT);
            sp_in.key    = req_reg.id;
            sp_in.value  = req_reg.partner_id;
            sp_in.hit    = (state_reg == S_COMMIT) && sp_out.hit;
            af_in.active = use_atom;
            af_in.wr     = is_ins;
            af_in.commit = (state_reg == S_COMMIT);
            af_in.key    = req_reg.id;
            af_in.value  = req_reg.partner_id;
            af_in.hit    = (state_reg == S_COMMIT) && af_out.hit;
            ar_in.active = use_atom;
            ar_in.wr     = is_ins;
            ar_in.commit = (state_reg == S_COMMIT);
            // reverse lookups search by the id, inserts key on the partner
            ar_in.key    = (req_reg.mode == rit_pkg::MODE_ATOM_REV) ? req_reg.id
                                                                    : req_reg.partner_id;
            ar_in.value  = req_reg.id;
            ar_in.hit    = (state_reg == S_COMMIT) && ar_out.hit;
        end
    end

    // search-pass outcome kept for the commit pass
    rit_pkg::tok_t sp_hold_reg, af_hold_reg, ar_hold_reg;

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (launch_reg)
                begin
                    // direct results need no table pass
                    if (!use_spec && !use_atom)
                    begin
                        rsp_next.result_id = req_reg.id;
                        rsp_next.status    = rit_pkg::ST_MISS;
                        unique case (req_reg.mode) inside
                            rit_pkg::MODE_O2N, rit_pkg::MODE_O2N_SPEC,
                            rit_pkg::MODE_N2O:
                            begin
                                if (req_reg.id == '0)
                                    rsp_next.status = rit_pkg::ST_MISS;
                                else if (req_reg.id == fr)
                                begin
                                    rsp_next.result_id = tr;
                                    rsp_next.status    = rit_pkg::ST_HIT;
                                end
                                else if (in_win_from)
                                begin
                                    rsp_next.result_id = req_reg.id - fb + tb;
                                    rsp_next.status    = rit_pkg::ST_HIT;
                                end
                            end
                            rit_pkg::MODE_CHK_OLD:
                                rsp_next.status = in_win_old ? rit_pkg::ST_HIT
                                                             : rit_pkg::ST_MISS;
                            rit_pkg::MODE_CHK_NEW:
                                rsp_next.status = in_win_new ? rit_pkg::ST_HIT
                                                             : rit_pkg::ST_MISS;
                            default: ;
                        endcase
                        state_next = S_OUT;
                    end
                end
                else if (pass_done)
                begin
                    rsp_next.result_id = req_reg.id;
                    if (is_ins)
                    begin
                        rsp_next.status = rit_pkg::ST_FULL;
                        if (use_spec ? (sp_out.hit || sp_out.free_seen)
                                     : ((af_out.hit || af_out.free_seen) &&
                                        (ar_out.hit || ar_out.free_seen)))
                        begin
                            rsp_next.status = rit_pkg::ST_STORED;
                            state_next      = S_COMMIT;
                        end
                        else
                            state_next = S_OUT;
                    end
                    else
                    begin
                        rsp_next.status = rit_pkg::ST_MISS;
                        if (use_spec ? sp_out.hit :
                            (req_reg.mode == rit_pkg::MODE_ATOM_FWD ? af_out.hit
                                                                    : ar_out.hit))
                        begin
                            rsp_next.status    = rit_pkg::ST_HIT;
                            rsp_next.result_id = use_spec ? sp_out.hit_value :
                                (req_reg.mode == rit_pkg::MODE_ATOM_FWD ?
                                 af_out.hit_value : ar_out.hit_value);
                        end
                        state_next = S_OUT;
                    end
                end
            end
            S_COMMIT:
            begin
                if (!launch_reg && pass_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // commit pass reuses the search hit flags, taken from the hold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= (state_reg == S_IDLE && accept) ||
                          (state_reg == S_SEARCH && state_next == S_COMMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
            req_reg <= req;
        if (state_reg == S_SEARCH && pass_done && !launch_reg)
        begin
            sp_hold_reg <= sp_out;
            af_hold_reg <= af_out;
            ar_hold_reg <= ar_out;
        end
    end

    // commit tokens take the hit flag from the finished search pass
    rit_pkg::tok_t sp_feed, af_feed, ar_feed;
    always_comb
    begin
        sp_feed = sp_in;
        af_feed = af_in;
        ar_feed = ar_in;
        if (state_reg == S_COMMIT)
        begin
            sp_feed.hit = sp_hold_reg.hit;
            af_feed.hit = af_hold_reg.hit;
            ar_feed.hit = ar_hold_reg.hit;
        end
    end

    rit_chain #(.DEPTH(SPECIAL_ENTRIES)) u_spec (
        .clk(clk), .rst_n(rst_n), .tok_in(sp_feed), .tok_out(sp_out)
    );
    rit_chain #(.DEPTH(ATOM_ENTRIES)) u_afwd (
        .clk(clk), .rst_n(rst_n), .tok_in(af_feed), .tok_out(af_out)
    );
    rit_chain #(.DEPTH(ATOM_ENTRIES)) u_arev (
        .clk(clk), .rst_n(rst_n), .tok_in(ar_feed), .tok_out(ar_out)
    );

endmodule

@@ rtl/core/rit_checker.sv @@
// ----------------------------------------------------------------------------
// rit_checker
// Port-level checks on the translator's handshakes and results.
// ----------------------------------------------------------------------------
module rit_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  rit_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  rit_pkg::rsp_t rsp
);

    // one transaction in flight: no request taken while a result waits
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("request taken with result pending");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed under stall");

    // a range check never reports stored or full
    a_chk_status: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.mode == rit_pkg::MODE_CHK_OLD ||
        req.mode == rit_pkg::MODE_CHK_NEW) |=> ##1
        (!rsp_valid || (rsp.status == rit_pkg::ST_HIT ||
                        rsp.status == rit_pkg::ST_MISS)))
        else $error("bad range check status");

endmodule

bind resource_id_translator rit_checker u_rit_checker (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
